// ===== src/dual_background_pixel_update_defines.svh =====
// ----------------------------------------------------------------------------
// Dual background pixel update: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DUAL_BACKGROUND_PIXEL_UPDATE_DEFINES_SVH
`define DUAL_BACKGROUND_PIXEL_UPDATE_DEFINES_SVH

// same-cycle implication
`define DBPU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DBPU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dbpu_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual background pixel update: package
// Item types, update classes, Q1.16 constants and small helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbpu_pkg;

  localparam int PIX_IDX_W  = 19;
  localparam int Q16_W      = 17;
  localparam int COLOUR_W   = 24;
  localparam int BG_PAIR_W  = 48;
  localparam int REG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [Q16_W-1:0] ONE_Q16       = 17'h10000;
  localparam logic [Q16_W-1:0] RATE_RESET    = 17'd3277;
  localparam logic [33:0]      HALF_Q16_WIDE = 34'd32768;

  // register select on paddr[2]
  localparam logic REG_LEARNING_RATE = 1'b0;
  localparam logic REG_BETWEEN_RATE  = 1'b1;

  typedef enum logic [1:0] {
    CLS_DARK   = 2'd0,
    CLS_BRIGHT = 2'd1,
    CLS_BAND   = 2'd2,
    CLS_SEED   = 2'd3
  } cls_t;

  typedef struct packed {
    logic                 mode;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [7:0]           src_ch0;
    logic [7:0]           src_ch1;
    logic [7:0]           src_ch2;
    logic [Q16_W-1:0]     touch_weight;
    logic [Q16_W-1:0]     freeze_weight;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bright_ch0;
    logic [7:0] bright_ch1;
    logic [7:0] bright_ch2;
    logic [7:0] dark_ch0;
    logic [7:0] dark_ch1;
    logic [7:0] dark_ch2;
    cls_t       update_class;
  } out_item_t;

  function automatic logic [Q16_W-1:0] sat_q16(input logic [Q16_W-1:0] v);
    sat_q16 = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic [9:0] csum(input logic [COLOUR_W-1:0] c);
    csum = 10'(c[7:0]) + 10'(c[15:8]) + 10'(c[23:16]);
  endfunction

endpackage

`default_nettype wire

// ===== src/dbpu_store.sv =====
// ----------------------------------------------------------------------------
// Dual background pixel update: frame store
// Bright and dark colours of each pixel side by side in one word;
// one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbpu_store import dbpu_pkg::*; #(
  parameter int DEPTH = 524288,
  parameter int AW    = 19
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [BG_PAIR_W-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [BG_PAIR_W-1:0] rd_data_r
);

  logic [BG_PAIR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/dbpu_idx.sv =====
// ----------------------------------------------------------------------------
// Dual background pixel update: index reduction
// Pixel index modulo frame size: reciprocal multiply in one stage,
// multiply-back and subtract in the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbpu_idx import dbpu_pkg::*; #(
  parameter int FRAME_PIXELS = 524288,
  parameter int AW           = 19
) (
  input  wire logic                 clk,
  input  wire logic                 ld,
  input  wire logic [PIX_IDX_W-1:0] pix_idx,
  output logic      [AW-1:0]        store_idx
);

  logic [PIX_IDX_W-1:0] x2_r;

  always_ff @(posedge clk) begin
    if (ld) begin
      x2_r <= pix_idx;
    end
  end

  if (FRAME_PIXELS < (1 << PIX_IDX_W)) begin : g_reduce
    localparam int              LG    = $clog2(FRAME_PIXELS);
    localparam int              SH    = PIX_IDX_W + LG;
    localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(FRAME_PIXELS) - 64'd1) / 64'(FRAME_PIXELS);
    localparam int              MW    = PIX_IDX_W + 2;
    localparam int              PW    = PIX_IDX_W + MW;
    localparam logic [MW-1:0]        RECIP_C = MW'(RECIP);
    localparam logic [PIX_IDX_W-1:0] N_C     = PIX_IDX_W'(FRAME_PIXELS);

    logic [PW-1:0]        prod;
    logic [PIX_IDX_W-1:0] q2_r;
    logic [PIX_IDX_W-1:0] rem;

    assign prod = PW'(pix_idx) * PW'(RECIP_C);

    always_ff @(posedge clk) begin
      if (ld) begin
        q2_r <= PIX_IDX_W'(prod >> SH);
      end
    end

    assign rem       = x2_r - q2_r * N_C;
    assign store_idx = AW'(rem);
  end else begin : g_pass
    assign store_idx = AW'(x2_r);
  end

endmodule

`default_nettype wire

// ===== src/dbpu_mix.sv =====
// ----------------------------------------------------------------------------
// Dual background pixel update: blend unit
// Registered per-channel products for both backgrounds, then
// round-to-nearest sum and clamp to 0..255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbpu_mix import dbpu_pkg::*; (
  input  wire logic                clk,
  input  wire logic                ld,
  input  wire logic [COLOUR_W-1:0] bright_bg,
  input  wire logic [COLOUR_W-1:0] dark_bg,
  input  wire logic [COLOUR_W-1:0] px,
  input  wire logic [Q16_W-1:0]    w_bright,
  input  wire logic [Q16_W-1:0]    w_dark,
  output logic      [COLOUR_W-1:0] bright_new,
  output logic      [COLOUR_W-1:0] dark_new
);

  localparam int PRW = 8 + Q16_W;
  localparam int SMW = PRW + 1;

  logic [PRW-1:0] keep_r [2][3];
  logic [PRW-1:0] take_r [2][3];
  logic [7:0]     res    [2][3];

  for (genvar s = 0; s < 2; s++) begin : g_store
    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [7:0]       bg_c;
      logic [7:0]       px_c;
      logic [Q16_W-1:0] w_c;
      logic [SMW-1:0]   sum;
      logic [SMW-17:0]  quo;

      assign bg_c = (s == 0) ? bright_bg[8*c +: 8] : dark_bg[8*c +: 8];
      assign px_c = px[8*c +: 8];
      assign w_c  = (s == 0) ? w_bright : w_dark;

      always_ff @(posedge clk) begin
        if (ld) begin
          keep_r[s][c] <= PRW'(bg_c) * PRW'(ONE_Q16 - w_c);
          take_r[s][c] <= PRW'(px_c) * PRW'(w_c);
        end
      end

      assign sum = SMW'(keep_r[s][c]) + SMW'(take_r[s][c]) + SMW'(HALF_Q16_WIDE);
      assign quo = sum[SMW-1:16];
      assign res[s][c] = (quo > (SMW-16)'(255)) ? 8'hFF : quo[7:0];
    end
  end

  assign bright_new = {res[0][2], res[0][1], res[0][0]};
  assign dark_new   = {res[1][2], res[1][1], res[1][0]};

endmodule

`default_nettype wire

// ===== src/dual_background_pixel_update.sv =====
// An accepted item passes through the stage 1, 2, 3 and 4 registers, then the output register.
// Throughput: one item per cycle while the output is not stalled; an item for the same
//   frame store entry as the item directly ahead of it waits for that write to the frame store.
// The frame store entries are undefined until seeded; no clearing pass.
// Reset (rst_n low, synchronous) empties the pipeline and restores both rates.
// ----------------------------------------------------------------------------
// Dual background pixel update: top level
// Five-stage pipeline: weight/index, reduce/read, classify, blend, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_background_pixel_update_defines.svh"

module dual_background_pixel_update import dbpu_pkg::*; #(
  parameter int FRAME_PIXELS = 524288
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [REG_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  // configuration
  logic [Q16_W-1:0] lr_r, lr_nxt;
  logic [Q16_W-1:0] br_r, br_nxt;
  logic             cfg_wr;

  // stage registers
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic                 s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt, out_v_nxt;
  in_item_t             s1_item_r;
  logic                 s2_mode_r, s3_mode_r;
  logic [COLOUR_W-1:0]  s2_px_r, s3_px_r;
  logic [Q16_W-1:0]     s2_touch_r;
  logic [33:0]          s2_wprod_r;
  logic [Q16_W-1:0]     s3_w_r;
  logic [AW-1:0]        s3_idx_r, s4_idx_r;
  cls_t                 s4_cls_r;
  out_item_t            out_r;

  // forwarding of store writes into stage 3
  logic                 fwd_v_r, fwd_v_nxt;
  logic [BG_PAIR_W-1:0] fwd_d_r;

  // flow control
  logic acc, rdy_o, rdy4, rdy3, rdy2, rdy1;
  logic mv1, mv2, mv3, mv4, hz;

  // datapath
  logic [Q16_W-1:0]     touch1, freeze1, lrs;
  logic [33:0]          wprod1;
  logic [33:0]          wround;
  logic [Q16_W-1:0]     w2;
  logic [AW-1:0]        idx2;
  logic [BG_PAIR_W-1:0] rd_q;
  logic [BG_PAIR_W-1:0] bg3;
  logic [COLOUR_W-1:0]  bright3, dark3;
  logic [COLOUR_W-1:0]  bright_mix3, dark_mix3;
  logic [9:0]           sum_px, sum_bright, sum_dark;
  logic [Q16_W-1:0]     wb3, wd3, brs;
  cls_t                 cls3;
  logic [COLOUR_W-1:0]  bright4, dark4;
  logic [BG_PAIR_W-1:0] wr_d;
  logic                 wr_en;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    lr_nxt = lr_r;
    br_nxt = br_r;
    prdata = '0;
    unique case (paddr[2])
      REG_LEARNING_RATE: begin
        prdata = APB_DATA_W'(lr_r);
        if (cfg_wr) lr_nxt = pwdata[Q16_W-1:0];
      end
      REG_BETWEEN_RATE: begin
        prdata = APB_DATA_W'(br_r);
        if (cfg_wr) br_nxt = pwdata[Q16_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= RATE_RESET;
      br_r <= RATE_RESET;
    end else begin
      lr_r <= lr_nxt;
      br_r <= br_nxt;
    end
  end

  // ---------------- flow control ----------------
  assign rdy_o = !out_v_r || !out_stall;
  assign mv4   = s4_v_r && rdy_o;
  assign rdy4  = !s4_v_r || rdy_o;
  assign hz    = s3_v_r && s4_v_r && (s3_idx_r == s4_idx_r);
  assign mv3   = s3_v_r && rdy4 && !hz;
  assign rdy3  = !s3_v_r || (rdy4 && !hz);
  assign mv2   = s2_v_r && rdy3;
  assign rdy2  = !s2_v_r || rdy3;
  assign mv1   = s1_v_r && rdy2;
  assign rdy1  = !s1_v_r || rdy2;

  assign in_stall = !rdy1;
  assign acc      = in_valid && !in_stall;

  assign s1_v_nxt  = acc || (s1_v_r && !mv1);
  assign s2_v_nxt  = mv1 || (s2_v_r && !mv2);
  assign s3_v_nxt  = mv2 || (s3_v_r && !mv3);
  assign s4_v_nxt  = mv3 || (s4_v_r && !mv4);
  assign out_v_nxt = mv4 || (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      s4_v_r  <= s4_v_nxt;
      out_v_r <= out_v_nxt;
      fwd_v_r <= fwd_v_nxt;
    end
  end

  // ---------------- stage 1: weight product ----------------
  assign touch1  = sat_q16(s1_item_r.touch_weight);
  assign freeze1 = sat_q16(s1_item_r.freeze_weight);
  assign lrs     = sat_q16(lr_r);
  assign wprod1  = 34'(ONE_Q16 - freeze1) * 34'(lrs);

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r <= in_data;
    end
    if (mv1) begin
      s2_mode_r  <= s1_item_r.mode;
      s2_px_r    <= {s1_item_r.src_ch2, s1_item_r.src_ch1, s1_item_r.src_ch0};
      s2_touch_r <= touch1;
      s2_wprod_r <= wprod1;
    end
  end

  dbpu_idx #(
    .FRAME_PIXELS (FRAME_PIXELS),
    .AW           (AW)
  ) u_idx (
    .clk       (clk),
    .ld        (mv1),
    .pix_idx   (s1_item_r.pixel_index),
    .store_idx (idx2)
  );

  // ---------------- stage 2: weight rounding, store read ----------------
  assign wround = (s2_wprod_r + HALF_Q16_WIDE) >> 16;
  assign w2     = (s2_touch_r != '0) ? s2_touch_r : sat_q16(wround[Q16_W-1:0]);

  always_ff @(posedge clk) begin
    if (mv2) begin
      s3_mode_r <= s2_mode_r;
      s3_px_r   <= s2_px_r;
      s3_w_r    <= w2;
      s3_idx_r  <= idx2;
    end
  end

  dbpu_store #(
    .DEPTH (FRAME_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (s4_idx_r),
    .wr_data   (wr_d),
    .rd_en     (mv2),
    .rd_addr   (idx2),
    .rd_data_r (rd_q)
  );

  // write landing on the entry being read, or on the entry held in stage 3
  always_comb begin
    fwd_v_nxt = fwd_v_r;
    if (mv2) begin
      fwd_v_nxt = wr_en && (s4_idx_r == idx2);
    end else if (s3_v_r && wr_en && (s4_idx_r == s3_idx_r)) begin
      fwd_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2 || (s3_v_r && wr_en && (s4_idx_r == s3_idx_r))) begin
      fwd_d_r <= wr_d;
    end
  end

  // ---------------- stage 3: classify ----------------
  assign bg3        = fwd_v_r ? fwd_d_r : rd_q;
  assign bright3    = bg3[COLOUR_W-1:0];
  assign dark3      = bg3[BG_PAIR_W-1:COLOUR_W];
  assign sum_px     = csum(s3_px_r);
  assign sum_bright = csum(bright3);
  assign sum_dark   = csum(dark3);
  assign brs        = sat_q16(br_r);

  // a seed never looks at the stored colours, which may not exist yet
  assign bright_mix3 = s3_mode_r ? s3_px_r : bright3;
  assign dark_mix3   = s3_mode_r ? s3_px_r : dark3;

  // weight 0 keeps a background, weight one copies the pixel
  always_comb begin
    if (s3_mode_r) begin
      cls3 = CLS_SEED;
      wb3  = ONE_Q16;
      wd3  = ONE_Q16;
    end else if (sum_px < sum_dark) begin
      cls3 = CLS_DARK;
      wb3  = '0;
      wd3  = s3_w_r;
    end else if (sum_px > sum_bright) begin
      cls3 = CLS_BRIGHT;
      wb3  = s3_w_r;
      wd3  = '0;
    end else begin
      cls3 = CLS_BAND;
      wb3  = brs;
      wd3  = brs;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      s4_cls_r <= cls3;
      s4_idx_r <= s3_idx_r;
    end
  end

  // ---------------- stage 4: blend, store write ----------------
  dbpu_mix u_mix (
    .clk        (clk),
    .ld         (mv3),
    .bright_bg  (bright_mix3),
    .dark_bg    (dark_mix3),
    .px         (s3_px_r),
    .w_bright   (wb3),
    .w_dark     (wd3),
    .bright_new (bright4),
    .dark_new   (dark4)
  );

  assign wr_d  = {dark4, bright4};
  assign wr_en = mv4;

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (mv4) begin
      out_r.bright_ch0   <= bright4[7:0];
      out_r.bright_ch1   <= bright4[15:8];
      out_r.bright_ch2   <= bright4[23:16];
      out_r.dark_ch0     <= dark4[7:0];
      out_r.dark_ch1     <= dark4[15:8];
      out_r.dark_ch2     <= dark4[23:16];
      out_r.update_class <= s4_cls_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ---------------- checks ----------------
  `DBPU_ASSERT_NEXT(a_out_fill, mv4, out_v_r, "blended item did not reach the output register")
  `DBPU_ASSERT_NEXT(a_fwd_patch, s3_v_r && !mv2 && mv4 && (s4_idx_r == s3_idx_r), fwd_v_r && (fwd_d_r == $past(wr_d)), "store write not forwarded to waiting item")
  `DBPU_ASSERT_NOW(a_seed_equal, out_v_r && (out_r.update_class == CLS_SEED), (out_r.bright_ch0 == out_r.dark_ch0) && (out_r.bright_ch1 == out_r.dark_ch1) && (out_r.bright_ch2 == out_r.dark_ch2), "seeded backgrounds differ")

endmodule

`default_nettype wire
